FILE: rtl/ppim_pkg.sv
// ----------------------------------------------------------------------------
// ppim_pkg
// Shared types for the point projection and interaction-matrix pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ppim_pkg;

  // per-point flags that travel down the pipeline next to the data
  typedef struct packed {
    logic invalid;
    logic x_neg;
    logic y_neg;
  } ppim_flags_t;

endpackage : ppim_pkg

`default_nettype wire

FILE: rtl/ppim_div.sv
// ----------------------------------------------------------------------------
// ppim_div
// Pipelined restoring divider, several lanes over one shared divisor.
// Gives min(floor(numer * 2^FRAC / denom), 2^(DEN_W-1)) per lane, one quotient
// bit per stage, so a new set of operands can enter every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ppim_div import ppim_pkg::*; #(
  parameter int LANES  = 1,
  parameter int NUM_W  = 24,
  parameter int DEN_W  = 24,
  parameter int FRAC   = 16,
  parameter int SIDE_W = 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire ppim_flags_t                   in_flags,
  input  wire logic [SIDE_W-1:0]             in_side,
  input  wire logic [LANES-1:0][NUM_W-1:0]   numer,
  input  wire logic [DEN_W-1:0]              denom,
  output logic                               out_valid,
  output ppim_flags_t                        out_flags,
  output logic [SIDE_W-1:0]                  out_side,
  output logic [LANES-1:0][DEN_W-1:0]        quot
);

  localparam int NW    = NUM_W + FRAC;
  localparam int HW    = NW - DEN_W + 1;
  localparam int CMP_W = (HW > DEN_W) ? HW : DEN_W;
  localparam int STEPS = DEN_W - 1;
  localparam logic [DEN_W-1:0] LIM = {1'b1, {(DEN_W-1){1'b0}}};

  // stage 0 holds the overflow pre-check, stages 1..STEPS one quotient bit each
  logic                valid [STEPS+1];
  ppim_flags_t         flg   [STEPS+1];
  logic [SIDE_W-1:0]   side  [STEPS+1];
  logic [DEN_W-1:0]    den   [STEPS+1];
  logic [DEN_W-1:0]    rem   [LANES][STEPS+1];
  logic [STEPS-1:0]    low   [LANES][STEPS+1];
  logic [STEPS-1:0]    quo   [LANES][STEPS+1];
  logic                ovf   [LANES][STEPS+1];

  logic [NW-1:0]       wide  [LANES];
  logic [CMP_W-1:0]    hi    [LANES];
  logic                ovf0  [LANES];
  logic [DEN_W-1:0]    rem0  [LANES];
  logic [DEN_W:0]      trial [LANES][STEPS];
  logic [DEN_W:0]      diff  [LANES][STEPS];
  logic                ge    [LANES][STEPS];

  // quotient reaches 2^(DEN_W-1) exactly when the top part of the dividend
  // is not below the divisor
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      wide[l] = {numer[l], {FRAC{1'b0}}};
      hi[l]   = CMP_W'(wide[l][NW-1:DEN_W-1]);
      ovf0[l] = hi[l] >= CMP_W'(denom);
      rem0[l] = ovf0[l] ? '0 : DEN_W'(hi[l]);
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      for (int s = 0; s < STEPS; s++) begin
        trial[l][s] = {rem[l][s], low[l][s][STEPS-1]};
        diff[l][s]  = trial[l][s] - {1'b0, den[s]};
        ge[l][s]    = trial[l][s] >= {1'b0, den[s]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= STEPS; s++) valid[s] <= 1'b0;
    end else begin
      valid[0] <= in_valid;
      for (int s = 0; s < STEPS; s++) valid[s+1] <= valid[s];
    end
  end

  always_ff @(posedge clk) begin
    flg[0]  <= in_flags;
    side[0] <= in_side;
    den[0]  <= denom;
    for (int l = 0; l < LANES; l++) begin
      rem[l][0] <= rem0[l];
      low[l][0] <= wide[l][DEN_W-2:0];
      quo[l][0] <= '0;
      ovf[l][0] <= ovf0[l];
    end
    for (int s = 0; s < STEPS; s++) begin
      flg[s+1]  <= flg[s];
      side[s+1] <= side[s];
      den[s+1]  <= den[s];
      for (int l = 0; l < LANES; l++) begin
        rem[l][s+1] <= ge[l][s] ? diff[l][s][DEN_W-1:0] : trial[l][s][DEN_W-1:0];
        low[l][s+1] <= {low[l][s][STEPS-2:0], 1'b0};
        quo[l][s+1] <= {quo[l][s][STEPS-2:0], ge[l][s]};
        ovf[l][s+1] <= ovf[l][s];
      end
    end
  end

  always_comb begin
    out_valid = valid[STEPS];
    out_flags = flg[STEPS];
    out_side  = side[STEPS];
    for (int l = 0; l < LANES; l++) begin
      quot[l] = ovf[l][STEPS] ? LIM : {1'b0, quo[l][STEPS]};
    end
  end

`ifndef SYNTHESIS
  a_quot_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> quot[0] <= LIM)
    else $error("ppim_div: quotient above saturation limit");
  a_valid_follows: assert property (@(posedge clk) disable iff (rst)
    valid[0] |=> valid[1])
    else $error("ppim_div: valid bit lost between stages");
  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    valid[1] && !ovf[0][1] && den[1] != '0 |-> rem[0][1] < den[1])
    else $error("ppim_div: partial remainder not below divisor");
`endif

endmodule : ppim_div

`default_nettype wire

FILE: rtl/point_projection_interaction_matrix.sv
// ----------------------------------------------------------------------------
// point_projection_interaction_matrix
// Projects a camera-frame point to normalized image coordinates and forms the
// distinct terms of its 2x6 point interaction matrix, all saturated.
// ----------------------------------------------------------------------------
// start reaches done via input register, projection divider, clamp register,
//   depth divider, product registers and output register
// throughput: one point per cycle, busy stays low outside reset
// reset: synchronous, clears every pipeline valid bit; busy is high during reset
// ----------------------------------------------------------------------------
`default_nettype none

module point_projection_interaction_matrix import ppim_pkg::*; #(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [COORD_WIDTH-1:0] point_x,
  input  wire logic signed [COORD_WIDTH-1:0] point_y,
  input  wire logic signed [COORD_WIDTH-1:0] point_z,
  output logic                               done,
  output logic signed [COORD_WIDTH-1:0]      image_x,
  output logic signed [COORD_WIDTH-1:0]      image_y,
  output logic signed [COORD_WIDTH-1:0]      neg_inv_depth,
  output logic signed [COORD_WIDTH-1:0]      x_over_depth,
  output logic signed [COORD_WIDTH-1:0]      y_over_depth,
  output logic signed [COORD_WIDTH-1:0]      x_times_y,
  output logic signed [COORD_WIDTH-1:0]      neg_one_plus_x_sq,
  output logic signed [COORD_WIDTH-1:0]      one_plus_y_sq,
  output logic                               depth_invalid
);

  localparam int W     = COORD_WIDTH;
  localparam int MAG_W = (W > FRAC_BITS) ? W : FRAC_BITS + 1;
  localparam int H     = (W + 1) / 2;
  localparam int PW    = 2 * W;
  localparam int PH    = PW - FRAC_BITS;
  localparam int PCW   = (PH > W) ? PH : W;
  localparam logic [W-1:0]     LIM     = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0]     LIM_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic [MAG_W-1:0] ONE     = MAG_W'(1) << FRAC_BITS;

  function automatic logic [W-1:0] enc(input logic neg, input logic [W-1:0] m);
    enc = neg ? (~m + 1'b1) : m;
  endfunction

  // positive side stops one short of the limit
  function automatic logic [W-1:0] clamp_mag(input logic neg, input logic [W-1:0] m);
    clamp_mag = (!neg && m > LIM_POS) ? LIM_POS : m;
  endfunction

  assign busy = rst;

  // ---------------- input register ----------------
  logic         in_v;
  logic [W-1:0] px, py, pz;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else begin
      in_v <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    px <= point_x;
    py <= point_y;
    pz <= point_z;
  end

  ppim_flags_t             in_flags;
  logic [W-1:0]            xm, ym;
  logic [2:0][MAG_W-1:0]   b1_num;

  always_comb begin
    xm = px[W-1] ? (~px + 1'b1) : px;
    ym = py[W-1] ? (~py + 1'b1) : py;
    in_flags.invalid = pz[W-1] || (pz == '0);
    in_flags.x_neg   = px[W-1];
    in_flags.y_neg   = py[W-1];
    b1_num[0] = MAG_W'(xm);
    b1_num[1] = MAG_W'(ym);
    b1_num[2] = ONE;
  end

  // ---------------- first divider bank: X/Z, Y/Z, 1/Z ----------------
  logic                  b1_v;
  ppim_flags_t           b1_flags;
  logic [W-1:0]          b1_z;
  logic [2:0][W-1:0]     b1_q;

  ppim_div #(
    .LANES(3), .NUM_W(MAG_W), .DEN_W(W), .FRAC(FRAC_BITS), .SIDE_W(W)
  ) u_div_proj (
    .clk(clk), .rst(rst),
    .in_valid(in_v), .in_flags(in_flags), .in_side(pz),
    .numer(b1_num), .denom(pz),
    .out_valid(b1_v), .out_flags(b1_flags), .out_side(b1_z), .quot(b1_q)
  );

  // ---------------- clamp register ----------------
  logic          c_v;
  ppim_flags_t   c_flags;
  logic [W-1:0]  c_mx, c_my, c_ninv, c_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else begin
      c_v <= b1_v;
    end
  end

  always_ff @(posedge clk) begin
    c_flags <= b1_flags;
    c_mx    <= clamp_mag(b1_flags.x_neg, b1_q[0]);
    c_my    <= clamp_mag(b1_flags.y_neg, b1_q[1]);
    c_ninv  <= b1_q[2];
    c_z     <= b1_z;
  end

  // ---------------- second divider bank: x/Z, y/Z ----------------
  logic [1:0][MAG_W-1:0] b2_num;
  logic                  b2_v;
  ppim_flags_t           b2_flags;
  logic [3*W-1:0]        b2_side;
  logic [1:0][W-1:0]     b2_q;

  assign b2_num[0] = MAG_W'(c_mx);
  assign b2_num[1] = MAG_W'(c_my);

  ppim_div #(
    .LANES(2), .NUM_W(MAG_W), .DEN_W(W), .FRAC(FRAC_BITS), .SIDE_W(3*W)
  ) u_div_depth (
    .clk(clk), .rst(rst),
    .in_valid(c_v), .in_flags(c_flags), .in_side({c_mx, c_my, c_ninv}),
    .numer(b2_num), .denom(c_z),
    .out_valid(b2_v), .out_flags(b2_flags), .out_side(b2_side), .quot(b2_q)
  );

  logic [W-1:0] b2_mx, b2_my, b2_ninv;
  assign b2_mx   = b2_side[3*W-1:2*W];
  assign b2_my   = b2_side[2*W-1:W];
  assign b2_ninv = b2_side[W-1:0];

  // ---------------- products: xy, xx, yy over split halves ----------------
  // lane 0: x*y, lane 1: x*x, lane 2: y*y
  logic [2:0][W-1:0] m_a, m_b;
  assign m_a[0] = b2_mx;  assign m_b[0] = b2_my;
  assign m_a[1] = b2_mx;  assign m_b[1] = b2_mx;
  assign m_a[2] = b2_my;  assign m_b[2] = b2_my;

  logic              p1_v, p2_v, p3_v;
  ppim_flags_t       p1_flags, p2_flags, p3_flags;
  logic [W-1:0]      p1_mx, p1_my, p1_ninv, p1_qx, p1_qy;
  logic [W-1:0]      p2_mx, p2_my, p2_ninv, p2_qx, p2_qy;
  logic [W-1:0]      p3_mx, p3_my, p3_ninv, p3_qx, p3_qy;
  logic [2*H-1:0]       pp_ll [3];
  logic [W-1:0]         pp_lh [3];
  logic [W-1:0]         pp_hl [3];
  logic [2*(W-H)-1:0]   pp_hh [3];
  logic [PW-1:0]        p2_cat [3];
  logic [W:0]           p2_mid [3];
  logic [PW-1:0]        prod   [3];
  logic [PW-FRAC_BITS-1:0] prod_hi [3];
  logic [W-1:0]         p3_pm  [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
      p2_v <= 1'b0;
      p3_v <= 1'b0;
    end else begin
      p1_v <= b2_v;
      p2_v <= p1_v;
      p3_v <= p2_v;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod[k]    = p2_cat[k] + (PW'(p2_mid[k]) << H);
      prod_hi[k] = prod[k][PW-1:FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    p1_flags <= b2_flags;
    p1_mx    <= b2_mx;
    p1_my    <= b2_my;
    p1_ninv  <= b2_ninv;
    p1_qx    <= b2_q[0];
    p1_qy    <= b2_q[1];
    for (int k = 0; k < 3; k++) begin
      pp_ll[k] <= m_a[k][H-1:0] * m_b[k][H-1:0];
      pp_lh[k] <= W'(m_a[k][H-1:0] * m_b[k][W-1:H]);
      pp_hl[k] <= W'(m_a[k][W-1:H] * m_b[k][H-1:0]);
      pp_hh[k] <= m_a[k][W-1:H] * m_b[k][W-1:H];
    end

    p2_flags <= p1_flags;
    p2_mx    <= p1_mx;
    p2_my    <= p1_my;
    p2_ninv  <= p1_ninv;
    p2_qx    <= p1_qx;
    p2_qy    <= p1_qy;
    for (int k = 0; k < 3; k++) begin
      p2_cat[k] <= {pp_hh[k], pp_ll[k]};
      p2_mid[k] <= (W+1)'(pp_lh[k]) + (W+1)'(pp_hl[k]);
    end

    p3_flags <= p2_flags;
    p3_mx    <= p2_mx;
    p3_my    <= p2_my;
    p3_ninv  <= p2_ninv;
    p3_qx    <= p2_qx;
    p3_qy    <= p2_qy;
    for (int k = 0; k < 3; k++) begin
      p3_pm[k] <= (PCW'(prod_hi[k]) > PCW'(LIM)) ? LIM : W'(prod_hi[k]);
    end
  end

  // ---------------- output register ----------------
  logic [MAG_W:0] sq_x, sq_y;
  logic [W-1:0]   sq_x_m, sq_y_m;
  logic           s_xy;

  always_comb begin
    s_xy   = p3_flags.x_neg ^ p3_flags.y_neg;
    sq_x   = (MAG_W+1)'(p3_pm[1]) + (MAG_W+1)'(ONE);
    sq_y   = (MAG_W+1)'(p3_pm[2]) + (MAG_W+1)'(ONE);
    sq_x_m = (sq_x > (MAG_W+1)'(LIM))     ? LIM     : W'(sq_x);
    sq_y_m = (sq_y > (MAG_W+1)'(LIM_POS)) ? LIM_POS : W'(sq_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= p3_v;
    end
  end

  always_ff @(posedge clk) begin
    depth_invalid <= p3_flags.invalid;
    if (p3_flags.invalid) begin
      image_x           <= '0;
      image_y           <= '0;
      neg_inv_depth     <= '0;
      x_over_depth      <= '0;
      y_over_depth      <= '0;
      x_times_y         <= '0;
      neg_one_plus_x_sq <= '0;
      one_plus_y_sq     <= '0;
    end else begin
      image_x           <= $signed(enc(p3_flags.x_neg, p3_mx));
      image_y           <= $signed(enc(p3_flags.y_neg, p3_my));
      neg_inv_depth     <= $signed(enc(1'b1, p3_ninv));
      x_over_depth      <= $signed(enc(p3_flags.x_neg, clamp_mag(p3_flags.x_neg, p3_qx)));
      y_over_depth      <= $signed(enc(p3_flags.y_neg, clamp_mag(p3_flags.y_neg, p3_qy)));
      x_times_y         <= $signed(enc(s_xy, clamp_mag(s_xy, p3_pm[0])));
      neg_one_plus_x_sq <= $signed(enc(1'b1, sq_x_m));
      one_plus_y_sq     <= $signed(sq_y_m);
    end
  end

`ifndef SYNTHESIS
  a_invalid_zeroes: assert property (@(posedge clk) disable iff (rst)
    done && depth_invalid |-> image_x == '0 && image_y == '0 && neg_inv_depth == '0
      && x_over_depth == '0 && y_over_depth == '0 && x_times_y == '0
      && neg_one_plus_x_sq == '0 && one_plus_y_sq == '0)
    else $error("invalid depth with non-zero result");
  a_neg_sq_sign: assert property (@(posedge clk) disable iff (rst)
    done && !depth_invalid |-> neg_one_plus_x_sq[W-1])
    else $error("-(1+x^2) not negative");
  a_pos_sq_sign: assert property (@(posedge clk) disable iff (rst)
    done && !depth_invalid |-> !one_plus_y_sq[W-1] && one_plus_y_sq != '0)
    else $error("1+y^2 not positive");
  a_inv_depth_sign: assert property (@(posedge clk) disable iff (rst)
    done && !depth_invalid |-> neg_inv_depth[W-1] || neg_inv_depth == '0)
    else $error("-1/Z positive");
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe right after reset");
`endif

endmodule : point_projection_interaction_matrix

`default_nettype wire
